// ----- hw/rtl/asbx_pkg.sv -----
// ----------------------------------------------------------------------------
// AES S-box leakage model: shared package
// Field arithmetic over GF(2^8) modulo 0x11B, the AES affine map and the
// operand pair that moves between pipeline stages.
// ----------------------------------------------------------------------------
package asbx_pkg;

  localparam logic [7:0] GfReduce    = 8'h1B;
  localparam logic [7:0] GfTopBit    = 8'h80;
  localparam logic [7:0] AffineConst = 8'h63;

  // Two field elements held by one pipeline stage.
  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
  } pair_t;

  // Multiply by x with reduction.
  function automatic logic [7:0] gf_times_x(input logic [7:0] v);
    logic [7:0] r;
    r = {v[6:0], 1'b0};
    if ((v & GfTopBit) != 8'h00) begin
      r = r ^ GfReduce;
    end
    return r;
  endfunction

  // Shift-and-add product, most significant bit of b first.
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = 8'h00;
    for (int i = 7; i >= 0; i--) begin
      acc = gf_times_x(acc);
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  // Squaring is linear over GF(2), so synthesis reduces this to XOR gates.
  function automatic logic [7:0] gf_sq(input logic [7:0] a);
    return gf_mul(a, a);
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] v, input int unsigned n);
    logic [15:0] w;
    w = {v, v} << n;
    return w[15:8];
  endfunction

  function automatic logic [7:0] affine(input logic [7:0] v);
    return AffineConst ^ v ^ rotl8(v, 1) ^ rotl8(v, 2) ^ rotl8(v, 3) ^ rotl8(v, 4);
  endfunction

  function automatic logic [3:0] popcount8(input logic [7:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'b000, v[i]};
    end
    return n;
  endfunction

endpackage

// ----- hw/rtl/asbx_if.sv -----
// ----------------------------------------------------------------------------
// AES S-box leakage model: channel interfaces
// Valid/ready channels for the byte pair request and the S-box result.
// ----------------------------------------------------------------------------
interface asbx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] plaintext_byte;
  logic [7:0] key_guess;

  modport source (output valid, output plaintext_byte, output key_guess, input ready);
  modport sink   (input valid, input plaintext_byte, input key_guess, output ready);
endinterface

interface asbx_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sbox_value;
  logic [3:0] hamming_weight;

  modport source (output valid, output sbox_value, output hamming_weight, input ready);
  modport sink   (input valid, input sbox_value, input hamming_weight, output ready);
endinterface

// ----- hw/rtl/asbx_stage.sv -----
// ----------------------------------------------------------------------------
// AES S-box leakage model: pipeline stage register
// Holds one operand pair with its valid bit and loads whenever the stage
// is empty or its contents move on in the same cycle.
// ----------------------------------------------------------------------------
module asbx_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  asbx_pkg::pair_t data_i,
  output logic            valid_o,
  input  logic            ready_i,
  output asbx_pkg::pair_t data_o
);

  logic            valid_d, valid_q;
  asbx_pkg::pair_t data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;
  assign data_d  = (ready_o && valid_i) ? data_i : data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- hw/rtl/aes_sbox_leakage_model.sv -----
// ----------------------------------------------------------------------------
// AES S-box leakage model: top level
// Computes the S-box of plaintext xor key guess and its Hamming weight.
// ----------------------------------------------------------------------------
// The block takes one byte pair per cycle unless the result channel stalls
// the pipeline. The inverse x^254 is evaluated by a chain of
// five general field multiplications with the squarings folded in beside
// them; each multiplication has a register stage of its own, and a final
// output register applies the affine map and counts the one bits. Results
// leave in request order, and back-pressure on the result channel holds the
// pipeline without losing or repeating an item. There is no state between
// items and nothing to configure.
module aes_sbox_leakage_model (
  input  logic            clk_i,
  input  logic            rst_ni,
  asbx_in_if.sink         req_i,
  asbx_out_if.source      rsp_o
);

  localparam int unsigned NumStages = 5;

  logic            st_valid_in [NumStages];
  logic            st_ready_in [NumStages];
  asbx_pkg::pair_t st_data_in  [NumStages];
  logic            st_valid    [NumStages];
  logic            st_ready    [NumStages];
  asbx_pkg::pair_t st_data     [NumStages];

  logic [7:0] x_in;
  logic [7:0] x_sq;
  logic [7:0] x15;
  logic [7:0] x127;

  // Stage 1: x^3 and x^4.
  assign x_in = req_i.plaintext_byte ^ req_i.key_guess;
  assign x_sq = asbx_pkg::gf_sq(x_in);
  assign st_valid_in[0]  = req_i.valid;
  assign st_data_in[0].a = asbx_pkg::gf_mul(x_sq, x_in);
  assign st_data_in[0].b = asbx_pkg::gf_sq(x_sq);
  assign req_i.ready     = st_ready_in[0];

  // Stage 2: x^7 and x^8.
  assign st_valid_in[1]  = st_valid[0];
  assign st_data_in[1].a = asbx_pkg::gf_mul(st_data[0].a, st_data[0].b);
  assign st_data_in[1].b = asbx_pkg::gf_sq(st_data[0].b);

  // Stage 3: keep x^7, form x^15 and square twice to x^60.
  assign x15 = asbx_pkg::gf_mul(st_data[1].a, st_data[1].b);
  assign st_valid_in[2]  = st_valid[1];
  assign st_data_in[2].a = st_data[1].a;
  assign st_data_in[2].b = asbx_pkg::gf_sq(asbx_pkg::gf_sq(x15));

  // Stage 4: x^67, keep x^60.
  assign st_valid_in[3]  = st_valid[2];
  assign st_data_in[3].a = asbx_pkg::gf_mul(st_data[2].a, st_data[2].b);
  assign st_data_in[3].b = st_data[2].b;

  // Stage 5: x^127 squared gives the inverse x^254.
  assign x127 = asbx_pkg::gf_mul(st_data[3].b, st_data[3].a);
  assign st_valid_in[4]  = st_valid[3];
  assign st_data_in[4].a = asbx_pkg::gf_sq(x127);
  assign st_data_in[4].b = 8'h00;

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    asbx_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (st_valid_in[g]),
      .ready_o (st_ready_in[g]),
      .data_i  (st_data_in[g]),
      .valid_o (st_valid[g]),
      .ready_i (st_ready[g]),
      .data_o  (st_data[g])
    );
  end

  for (genvar g = 0; g < NumStages - 1; g++) begin : g_ready
    assign st_ready[g] = st_ready_in[g + 1];
  end

  // Output register: affine map and Hamming weight.
  logic       out_valid_d, out_valid_q;
  logic [7:0] sbox_d, sbox_q;
  logic [3:0] hw_d, hw_q;
  logic       out_load;
  logic [7:0] sbox_c;

  assign out_load = !out_valid_q || rsp_o.ready;
  assign st_ready[NumStages - 1] = out_load;
  assign sbox_c      = asbx_pkg::affine(st_data[NumStages - 1].a);
  assign out_valid_d = out_load ? st_valid[NumStages - 1] : out_valid_q;
  assign sbox_d      = (out_load && st_valid[NumStages - 1]) ? sbox_c : sbox_q;
  assign hw_d        = (out_load && st_valid[NumStages - 1]) ?
                       asbx_pkg::popcount8(sbox_c) : hw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sbox_q <= sbox_d;
    hw_q   <= hw_d;
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.sbox_value     = sbox_q;
  assign rsp_o.hamming_weight = hw_q;

endmodule
